FILE: sv/marker_relative_target_offset_macros.svh
// Assertion macros for the marker relative target offset block.
`ifndef MARKER_RELATIVE_TARGET_OFFSET_MACROS_SVH
`define MARKER_RELATIVE_TARGET_OFFSET_MACROS_SVH

// Assert that a property holds on every clock edge outside reset.
`define MRTO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert that when an antecedent holds, the consequent holds in the next cycle.
`define MRTO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/mrto_pkg.sv
// Shared types and constants for the marker relative target offset block.
package mrto_pkg;

  localparam int unsigned GuardBits = 8;
  localparam int unsigned MaxStages = 24;
  // Vector datapath width: 32 bit input times gain, guard bits, CORDIC growth.
  localparam int unsigned VecW = 44;

  localparam logic [34:0] HeadingTurnMul = 35'd17499271055;
  localparam logic [37:0] YawTurnMul = 38'd174992710553;
  localparam logic [30:0] GainInvQ31 = 31'd1304065748;

  localparam logic [0:0] RegTargetX = 1'b0;
  localparam logic [0:0] RegTargetY = 1'b1;

  typedef logic signed [VecW-1:0] vec_t;

  typedef struct packed {
    vec_t        rx;
    vec_t        ry;
    logic [31:0] rz;
    vec_t        tx;
    vec_t        ty;
    logic [31:0] tz;
    logic        seen;
  } cordic_t;

  function automatic logic [31:0] atan_turns(input int unsigned i);
    logic [31:0] r;
    case (i)
      0: r = 32'd536870912;
      1: r = 32'd316933406;
      2: r = 32'd167458907;
      3: r = 32'd85004756;
      4: r = 32'd42667331;
      5: r = 32'd21354465;
      6: r = 32'd10679838;
      7: r = 32'd5340245;
      8: r = 32'd2670163;
      9: r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/mrto_front.sv
// Front end: angle conversion, gain scaling and quadrant folding, three stages.
module mrto_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [31:0]      robot_heading_i,
  input  logic signed [31:0]      marker_x_i,
  input  logic signed [31:0]      marker_y_i,
  input  logic signed [31:0]      marker_yaw_i,
  input  logic                    marker_seen_i,
  input  logic signed [31:0]      target_x_i,
  input  logic signed [31:0]      target_y_i,
  output logic                    valid_o,
  output mrto_pkg::cordic_t       data_o
);

  localparam int unsigned Pre = 31 - mrto_pkg::GuardBits;

  // stage 1: products
  logic               v1_q;
  logic signed [66:0] ph_q, py_q;
  logic signed [63:0] mx_q, my_q, tx_q, ty_q;
  logic               s1_q;
  // stage 2: angles and scaled vectors
  logic               v2_q;
  logic [31:0]        ah_q, ay_q;
  mrto_pkg::vec_t     mx2_q, my2_q, tx2_q, ty2_q;
  logic               s2_q;

  logic [31:0] ah_d, ay_d, zr, za;
  mrto_pkg::vec_t mx2_d, my2_d, tx2_d, ty2_d;

  function automatic mrto_pkg::vec_t scale(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + (64'sd1 <<< (Pre - 1))) >>> Pre;
    return t[mrto_pkg::VecW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q <= 67'(robot_heading_i) * $signed({1'b0, mrto_pkg::HeadingTurnMul});
      py_q <= 67'(marker_yaw_i) * $signed({1'b0, mrto_pkg::YawTurnMul});
      mx_q <= 64'(marker_x_i) * $signed({1'b0, mrto_pkg::GainInvQ31});
      my_q <= 64'(marker_y_i) * $signed({1'b0, mrto_pkg::GainInvQ31});
      tx_q <= 64'(target_x_i) * $signed({1'b0, mrto_pkg::GainInvQ31});
      ty_q <= 64'(target_y_i) * $signed({1'b0, mrto_pkg::GainInvQ31});
      s1_q <= marker_seen_i;
      ah_q <= ah_d;
      ay_q <= ay_d;
      mx2_q <= mx2_d;
      my2_q <= my2_d;
      tx2_q <= tx2_d;
      ty2_q <= ty2_d;
      s2_q <= s1_q;
    end
  end

  always_comb begin
    ah_d = ph_q[55:24];
    ay_d = py_q[55:24];
    mx2_d = scale(mx_q);
    my2_d = scale(my_q);
    tx2_d = scale(tx_q);
    ty2_d = scale(ty_q);
    zr = 32'd0 - ah_q;
    za = 32'd0 - (ah_q + ay_q);
  end

  // stage 3: fold angles beyond a quarter turn
  function automatic logic fold(input logic [31:0] z);
    return (z[31] != z[30]) && (z != 32'h4000_0000);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_o.seen <= s2_q;
      if (fold(zr)) begin
        data_o.rx <= -mx2_q;
        data_o.ry <= -my2_q;
        data_o.rz <= zr + 32'h8000_0000;
      end else begin
        data_o.rx <= mx2_q;
        data_o.ry <= my2_q;
        data_o.rz <= zr;
      end
      if (fold(za)) begin
        data_o.tx <= -tx2_q;
        data_o.ty <= -ty2_q;
        data_o.tz <= za + 32'h8000_0000;
      end else begin
        data_o.tx <= tx2_q;
        data_o.ty <= ty2_q;
        data_o.tz <= za;
      end
    end
  end

endmodule

FILE: sv/mrto_stage.sv
// One CORDIC micro-rotation stage applied to both vectors.
module mrto_stage #(
  parameter int unsigned Idx = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  mrto_pkg::cordic_t data_i,
  output logic              valid_o,
  output mrto_pkg::cordic_t data_o
);

  localparam logic [31:0] Atan = mrto_pkg::atan_turns(Idx);

  mrto_pkg::cordic_t d;

  always_comb begin
    d = data_i;
    if (!data_i.rz[31]) begin
      d.rx = data_i.rx - (data_i.ry >>> Idx);
      d.ry = data_i.ry + (data_i.rx >>> Idx);
      d.rz = data_i.rz - Atan;
    end else begin
      d.rx = data_i.rx + (data_i.ry >>> Idx);
      d.ry = data_i.ry - (data_i.rx >>> Idx);
      d.rz = data_i.rz + Atan;
    end
    if (!data_i.tz[31]) begin
      d.tx = data_i.tx - (data_i.ty >>> Idx);
      d.ty = data_i.ty + (data_i.tx >>> Idx);
      d.tz = data_i.tz - Atan;
    end else begin
      d.tx = data_i.tx + (data_i.ty >>> Idx);
      d.ty = data_i.ty - (data_i.tx >>> Idx);
      d.tz = data_i.tz + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_o <= d;
    end
  end

endmodule

FILE: sv/marker_relative_target_offset.sv
// Marker relative target offset: CORDIC pipeline from robot-frame marker to world offset.
// Fully pipelined: one request accepted every cycle unless stalled; the stages are
// three front-end stages for angle multiply, gain scaling and quadrant fold, one per
// CORDIC micro-rotation, one for rounding and summing, one saturating output register.
// A stall on the output freezes the whole pipeline. Writes to the target offset take
// effect on requests accepted after the write.
module marker_relative_target_offset #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] robot_heading_i,
  input  logic signed [31:0] marker_x_i,
  input  logic signed [31:0] marker_y_i,
  input  logic signed [31:0] marker_yaw_i,
  input  logic               marker_seen_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] world_dx_o,
  output logic signed [31:0] world_dy_o,
  output logic               seen_out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  `include "marker_relative_target_offset_macros.svh"

  localparam int unsigned GB = mrto_pkg::GuardBits;

  logic signed [31:0] tgt_x_q, tgt_y_q;
  logic en;

  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_x_q <= '0;
      tgt_y_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mrto_pkg::RegTargetX: tgt_x_q <= cfg_data_i;
        mrto_pkg::RegTargetY: tgt_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic              vld [CORDIC_STAGES+1];
  mrto_pkg::cordic_t dat [CORDIC_STAGES+1];

  mrto_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .robot_heading_i, .marker_x_i, .marker_y_i, .marker_yaw_i, .marker_seen_i,
    .target_x_i(tgt_x_q), .target_y_i(tgt_y_q),
    .valid_o(vld[0]), .data_o(dat[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    mrto_stage #(.Idx(g)) u_stage (
      .clk_i, .rst_ni, .en_i(en), .valid_i(vld[g]), .data_i(dat[g]),
      .valid_o(vld[g+1]), .data_o(dat[g+1])
    );
  end

  // rounding and exact sum
  logic               sv_q, ss_q;
  logic signed [36:0] sx_q, sy_q;
  mrto_pkg::vec_t     rxr, ryr, txr, tyr;
  mrto_pkg::cordic_t  f;

  assign f = dat[CORDIC_STAGES];
  assign rxr = (f.rx + mrto_pkg::vec_t'(1 << (GB - 1))) >>> GB;
  assign ryr = (f.ry + mrto_pkg::vec_t'(1 << (GB - 1))) >>> GB;
  assign txr = (f.tx + mrto_pkg::vec_t'(1 << (GB - 1))) >>> GB;
  assign tyr = (f.ty + mrto_pkg::vec_t'(1 << (GB - 1))) >>> GB;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      sv_q <= vld[CORDIC_STAGES];
      out_valid_o <= sv_q;
    end
  end

  function automatic logic signed [31:0] sat(input logic signed [36:0] v);
    if (v > 37'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -37'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q <= rxr[36:0] + txr[36:0];
      sy_q <= ryr[36:0] + tyr[36:0];
      ss_q <= f.seen;
      world_dx_o <= sat(sx_q);
      world_dy_o <= sat(sy_q);
      seen_out_o <= ss_q;
    end
  end

  `MRTO_ASSERT(a_stall_only_full, !in_stall_o || out_valid_o, "stall without pending result")
  `MRTO_ASSERT_NEXT(a_hold_valid, out_valid_o && out_stall_i, out_valid_o,
                    "result dropped under stall")
  `MRTO_ASSERT_NEXT(a_hold_dx, out_valid_o && out_stall_i, $stable(world_dx_o),
                    "result changed under stall")

endmodule

FILE: bench/mrto_checker.sv
// Checker for the marker relative target offset block: predicts world offsets and compares.
module mrto_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [31:0] robot_heading_i,
  input  logic signed [31:0] marker_x_i,
  input  logic signed [31:0] marker_y_i,
  input  logic signed [31:0] marker_yaw_i,
  input  logic               marker_seen_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] world_dx_i,
  input  logic signed [31:0] world_dy_i,
  input  logic               seen_out_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output int                 pending_o,
  output int                 fail_count_o
);

  localparam int Stages = 16;
  localparam longint unsigned HeadMul = 64'd17499271055;
  localparam longint unsigned YawMul = 64'd174992710553;
  localparam longint GainInv = 64'd1304065748;

  typedef struct {
    logic [31:0] dx;
    logic [31:0] dy;
    logic        seen;
  } offset_t;

  const longint arctan_lut[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  offset_t     offset_q[$];
  logic [31:0] tgt_x, tgt_y;

  assign pending_o = offset_q.size();

  function automatic logic [31:0] bin_angle(logic signed [31:0] v, longint unsigned mul);
    longint unsigned p;
    p = longint'(v) * mul;
    return p[55:24];
  endfunction

  function automatic void cordic_rotate(input longint vx, input longint vy,
                                        input logic [31:0] a,
                                        output longint ox, output longint oy);
    longint x, y, z, dx, dy;
    x = (vx * GainInv + (64'sd1 <<< 22)) >>> 23;
    y = (vy * GainInv + (64'sd1 <<< 22)) >>> 23;
    z = longint'($signed(a));
    if (z > 64'sd1073741824 || z < -64'sd1073741824) begin
      x = -x;
      y = -y;
      z = (z > 0) ? z - 64'sd2147483648 : z + 64'sd2147483648;
    end
    for (int i = 0; i < Stages; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_lut[i];
      end else begin
        x += dx; y -= dy; z += arctan_lut[i];
      end
    end
    ox = x;
    oy = y;
  endfunction

  function automatic longint unguard(longint v);
    return (v + 128) >>> 8;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic offset_t predict_offset(logic signed [31:0] hd, logic signed [31:0] mx,
                                             logic signed [31:0] my, logic signed [31:0] yaw,
                                             logic seen);
    offset_t     r;
    logic [31:0] ah, ay;
    longint      rx, ry, tx, ty;
    ah = bin_angle(hd, HeadMul);
    ay = bin_angle(yaw, YawMul);
    cordic_rotate(longint'(mx), longint'(my), 32'd0 - ah, rx, ry);
    cordic_rotate(longint'($signed(tgt_x)), longint'($signed(tgt_y)), 32'd0 - (ah + ay),
                  tx, ty);
    r.dx = clamp32(unguard(rx) + unguard(tx));
    r.dy = clamp32(unguard(ry) + unguard(ty));
    r.seen = seen;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    offset_t e;
    int      errs;
    if (!rst_ni) begin
      tgt_x <= '0;
      tgt_y <= '0;
      fail_count_o <= 0;
      offset_q.delete();
    end else begin
      errs = 0;
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == mrto_pkg::RegTargetX) tgt_x <= cfg_data_i;
        else if (cfg_index_i == mrto_pkg::RegTargetY) tgt_y <= cfg_data_i;
      end
      if (in_valid_i && !in_stall_i)
        offset_q.push_back(predict_offset(robot_heading_i, marker_x_i, marker_y_i,
                                          marker_yaw_i, marker_seen_i));
      if (out_valid_i && !out_stall_i) begin
        if (offset_q.size() == 0) begin
          $error("result with no request outstanding");
          errs++;
        end else begin
          e = offset_q.pop_front();
          if (e.dx !== world_dx_i) begin
            $error("world_dx expected %0d got %0d", $signed(e.dx), world_dx_i);
            errs++;
          end
          if (e.dy !== world_dy_i) begin
            $error("world_dy expected %0d got %0d", $signed(e.dy), world_dy_i);
            errs++;
          end
          if (e.seen !== seen_out_i) begin
            $error("seen_out expected %0d got %0d", e.seen, seen_out_i);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
    end
  end
endmodule

FILE: bench/tb_marker_relative_target_offset.sv
// Testbench top for the marker relative target offset block: stimulus and verdict.
module tb_marker_relative_target_offset;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               in_valid_i = 0;
  logic               in_stall_o;
  logic signed [31:0] robot_heading_i = 0, marker_x_i = 0, marker_y_i = 0, marker_yaw_i = 0;
  logic               marker_seen_i = 0;
  logic               out_valid_o;
  logic               out_stall_i = 0;
  logic signed [31:0] world_dx_o, world_dy_o;
  logic               seen_out_o;
  logic               cfg_valid_i = 0;
  logic               cfg_ready_o;
  logic [0:0]         cfg_index_i = mrto_pkg::RegTargetX;
  logic [31:0]        cfg_data_i = 0;
  int                 pending, fails;
  bit                 calm = 0;
  int                 cycles = 0;

  marker_relative_target_offset dut (.*);

  mrto_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .robot_heading_i, .marker_x_i,
    .marker_y_i, .marker_yaw_i, .marker_seen_i, .out_valid_i(out_valid_o), .out_stall_i,
    .world_dx_i(world_dx_o), .world_dy_i(world_dy_o), .seen_out_i(seen_out_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .pending_o(pending), .fail_count_o(fails));

  initial forever #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 300000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 38);

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      3: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h0fffffff)) - 32'sh08000000);
    endcase
  endfunction

  task automatic send_request(logic [31:0] hd, logic [31:0] mx, logic [31:0] my,
                              logic [31:0] yaw, logic seen);
    while (!calm && $urandom_range(99) < 38) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    robot_heading_i <= hd;
    marker_x_i <= mx;
    marker_y_i <= my;
    marker_yaw_i <= yaw;
    marker_seen_i <= seen;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] data);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
  endtask

  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] set_x[6] = '{32'h0, 32'h7fffffff, 32'h80000000, 32'h00010000, 0, 0};
    logic [31:0] set_y[6] = '{32'h0, 32'h80000000, 32'h7fffffff, 32'hfffe8000, 0, 0};
    logic [31:0] ext[4] = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        send_request(ext[i], ext[j], ext[3 - j], ext[(i + j) % 4], j[0]);
    send_request(32'd10294, 32'h00010000, 32'h0, 32'h0001921f, 1);
    send_request(32'h40000000, 32'h0, 32'h00010000, 32'hc0000000, 0);
    drain();
    for (int p = 0; p < 6; p++) begin
      if (p >= 4) begin
        set_x[p] = rand_word();
        set_y[p] = rand_word();
      end
      write_reg(mrto_pkg::RegTargetX, set_x[p]);
      write_reg(mrto_pkg::RegTargetY, set_y[p]);
      for (int n = 0; n < 320; n++) begin
        calm = (p == 2 && n >= 100 && n < 250);
        send_request(rand_word(), rand_word(), rand_word(), rand_word(), $urandom_range(1));
      end
      calm = 0;
      drain();
    end
    if (fails == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
